// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Types, request and status codes shared by the double-ended queue files.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int DEQ_DEPTH = 16;

	localparam logic [2:0] REQ_PEEK       = 3'd0;
	localparam logic [2:0] REQ_PUSH_FRONT = 3'd1;
	localparam logic [2:0] REQ_PUSH_BACK  = 3'd2;
	localparam logic [2:0] REQ_POP_FRONT  = 3'd3;
	localparam logic [2:0] REQ_POP_BACK   = 3'd4;
	localparam logic [2:0] REQ_CLEAR      = 3'd5;
	localparam logic [2:0] REQ_REVERSE    = 3'd6;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_UNDERFLOW = 2'd1;
	localparam logic [1:0] STAT_OVERFLOW  = 2'd2;

	typedef struct packed {
		logic [2:0]         req_type;
		logic signed [31:0] push_value;
	} deq_req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] front_value;
		logic signed [31:0] back_value;
		logic [4:0]         entry_count;
		logic               is_empty;
	} deq_rsp_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic load;
	} deq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
	} deq_stat_t;

endpackage

// ===== rtl/core/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// ===== rtl/core/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer: capture a request, execute it, read both ends, load the result.
// ----------------------------------------------------------------------------
module deq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  deq_pkg::deq_stat_t stat,
	output deq_pkg::deq_cmd_t  cmd
);

	import deq_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;
	localparam logic [1:0] ST_LOAD = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign req_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		cmd.load    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_READ;
			end
			ST_READ: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				// hold until the output register is free
				if (stat.out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/deq_dp.sv =====
// ----------------------------------------------------------------------------
// deq_dp
// Datapath: ring pointers, count, direction flag, entry RAM, result register.
// ----------------------------------------------------------------------------
module deq_dp #(
	parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  deq_pkg::deq_req_t  req,
	input  deq_pkg::deq_cmd_t  cmd,
	output deq_pkg::deq_stat_t stat,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output deq_pkg::deq_rsp_t  rsp
);

	import deq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	deq_req_t          req_q;
	logic [AW-1:0]     head_q;
	logic [CW-1:0]     count_q;
	logic              rev_q;
	logic [1:0]        status_q;
	deq_rsp_t          rsp_q;
	logic              rsp_valid_q;

	logic [AW-1:0]     head_d;
	logic [CW-1:0]     count_d;
	logic              rev_d;
	logic [1:0]        status_d;

	logic [AW-1:0]     head_inc;
	logic [AW-1:0]     head_dec;
	logic [SW-1:0]     tail_sum;
	logic [SW-1:0]     last_sum;
	logic [AW-1:0]     tail_slot;
	logic [AW-1:0]     last_slot;
	logic              full;
	logic              empty;
	logic              at_low;

	logic              we;
	logic [AW-1:0]     waddr;
	logic [31:0]       rdata_lo;
	logic [31:0]       rdata_hi;
	logic signed [31:0] lo_val;
	logic signed [31:0] hi_val;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;

	// slot just past the high end, and slot of the high end; on a non-empty queue
	// both sums stay below twice the depth, so one conditional subtract wraps them
	assign tail_sum  = SW'(head_q) + SW'(count_q);
	assign last_sum  = tail_sum - 1'b1;
	assign tail_slot = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
	assign last_slot = (last_sum >= SW'(DEPTH)) ? AW'(last_sum - SW'(DEPTH)) : AW'(last_sum);

	always_comb begin
		head_d   = head_q;
		count_d  = count_q;
		rev_d    = rev_q;
		status_d = STAT_OK;
		we       = 1'b0;
		waddr    = tail_slot;
		at_low   = 1'b0;
		if (req_q.req_type inside {REQ_PUSH_FRONT, REQ_PUSH_BACK}) begin
			at_low = ((req_q.req_type == REQ_PUSH_FRONT) == !rev_q);
			if (full) begin
				status_d = STAT_OVERFLOW;
			end else begin
				we      = 1'b1;
				count_d = count_q + 1'b1;
				if (at_low) begin
					head_d = head_dec;
					waddr  = head_dec;
				end
			end
		end else if (req_q.req_type inside {REQ_POP_FRONT, REQ_POP_BACK}) begin
			at_low = ((req_q.req_type == REQ_POP_FRONT) == !rev_q);
			if (empty) begin
				status_d = STAT_UNDERFLOW;
			end else begin
				count_d = count_q - 1'b1;
				if (at_low) begin
					head_d = head_inc;
				end
			end
		end else if (req_q.req_type == REQ_CLEAR) begin
			head_d  = '0;
			count_d = '0;
			rev_d   = 1'b0;
		end else if (req_q.req_type == REQ_REVERSE) begin
			rev_d = !rev_q;
		end
	end

	deq_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (cmd.exec && we),
		.waddr   (waddr),
		.wdata   (req_q.push_value),
		.raddr_a (head_q),
		.raddr_b (last_slot),
		.rdata_a (rdata_lo),
		.rdata_b (rdata_hi)
	);

	assign lo_val = empty ? -32'sd1 : $signed(rdata_lo);
	assign hi_val = empty ? -32'sd1 : $signed(rdata_hi);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.exec) begin
			status_q <= status_d;
		end
		if (cmd.load) begin
			rsp_q.status      <= status_q;
			rsp_q.front_value <= rev_q ? hi_val : lo_val;
			rsp_q.back_value  <= rev_q ? lo_val : hi_val;
			rsp_q.entry_count <= 5'(count_q);
			rsp_q.is_empty    <= empty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			rev_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				head_q  <= head_d;
				count_q <= count_d;
				rev_q   <= rev_d;
			end
			if (cmd.load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign stat.out_free = !rsp_valid_q || !rsp_stall;
	assign rsp_valid     = rsp_valid_q;
	assign rsp           = rsp_q;

endmodule

// ===== rtl/core/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit words kept as a ring of DEPTH RAM entries.
// Each request (peek, push front/back, pop front/back, clear, reverse) gives
// one beat back with status, front and back values (-1 when empty), count and
// an empty flag. The accepting edge captures the request. Then come three
// steps: execute (pointer and count update plus RAM write), RAM read of
// both ends, and result load, after which the result beat is presented.
// The sequencer takes one request at a time, so a new request is accepted
// only after the last one has loaded its result. The result register holds a
// beat while the next request is taken. A result that cannot load because the
// previous beat is still stalled holds the sequencer in its load step. Reverse
// flips a direction flag and costs the same as any other request.
// ----------------------------------------------------------------------------
module double_ended_queue #(
	parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  deq_pkg::deq_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output deq_pkg::deq_rsp_t rsp
);

	import deq_pkg::*;

	deq_cmd_t  cmd;
	deq_stat_t stat;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	deq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ===== rtl/core/deq_chk.sv =====
// ----------------------------------------------------------------------------
// deq_chk
// Port-level checks for the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module deq_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input deq_pkg::deq_rsp_t rsp
);

	import deq_pkg::*;

	// a stalled result beat holds
	`ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
	// an empty queue reports zero entries and -1 at both ends
	`ASSERT_NOW(a_empty_count, rsp_valid && rsp.is_empty, rsp.entry_count == 5'd0)
	`ASSERT_NOW(a_empty_ends, rsp_valid && rsp.is_empty,
		(rsp.front_value == -32'sd1) && (rsp.back_value == -32'sd1))
	// underflow leaves the queue empty
	`ASSERT_NOW(a_underflow_empty, rsp_valid && (rsp.status == STAT_UNDERFLOW), rsp.is_empty)
	// one request at a time: busy right after an accept
	`ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

endmodule

bind double_ended_queue deq_chk u_chk (.*);

// ===== sim/double_ended_queue_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_chk
// Watches the request and reply channels of the deque and keeps its own copy
// of the ring, head, count and direction flag. Each accepted request beat
// yields one predicted reply. Each accepted reply beat is compared field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module double_ended_queue_chk (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_stall,
	input  deq_pkg::deq_req_t req,
	input  logic              rsp_valid,
	input  logic              rsp_stall,
	input  deq_pkg::deq_rsp_t rsp,
	output int                mismatches,
	output int                outstanding
);

	import deq_pkg::*;

	localparam logic signed [31:0] EMPTY_WORD = -32'sd1;

	logic signed [31:0] ring [DEQ_DEPTH];
	int unsigned        head_slot = 0;
	int unsigned        fill      = 0;
	logic               flipped   = 1'b0;

	deq_rsp_t pending_replies [$];
	int       reply_idx = 0;

	function automatic deq_rsp_t apply_request(input deq_req_t r);
		deq_rsp_t           res;
		logic               at_low;
		logic signed [31:0] low_word;
		logic signed [31:0] high_word;
		res.status = STAT_OK;
		case (r.req_type)
			REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
				at_low = (r.req_type == REQ_PUSH_FRONT) ^ flipped;
				if (fill >= DEQ_DEPTH) begin
					res.status = STAT_OVERFLOW;
				end else if (at_low) begin
					head_slot = (head_slot + DEQ_DEPTH - 1) % DEQ_DEPTH;
					ring[head_slot] = r.push_value;
					fill++;
				end else begin
					ring[(head_slot + fill) % DEQ_DEPTH] = r.push_value;
					fill++;
				end
			end
			REQ_POP_FRONT, REQ_POP_BACK: begin
				at_low = (r.req_type == REQ_POP_FRONT) ^ flipped;
				if (fill == 0) begin
					res.status = STAT_UNDERFLOW;
				end else if (at_low) begin
					head_slot = (head_slot + 1) % DEQ_DEPTH;
					fill--;
				end else begin
					fill--;
				end
			end
			REQ_CLEAR: begin
				fill      = 0;
				head_slot = 0;
				flipped   = 1'b0;
			end
			REQ_REVERSE: flipped = ~flipped;
			default: ;
		endcase
		if (fill == 0) begin
			low_word  = EMPTY_WORD;
			high_word = EMPTY_WORD;
		end else begin
			low_word  = ring[head_slot];
			high_word = ring[(head_slot + fill - 1) % DEQ_DEPTH];
		end
		res.front_value = flipped ? high_word : low_word;
		res.back_value  = flipped ? low_word : high_word;
		res.entry_count = fill[4:0];
		res.is_empty    = (fill == 0);
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t reply %0d: %s got %0h expected %0h", $realtime, reply_idx, what,
			got, want);
		mismatches++;
	endtask

	task automatic compare_reply(input deq_rsp_t got);
		deq_rsp_t want;
		if (pending_replies.size() == 0) begin
			report_mismatch("beat with no request pending", '0, '0);
			return;
		end
		want = pending_replies[0];
		pending_replies.delete(0);
		if (got.status !== want.status)
			report_mismatch("status", 32'(got.status), 32'(want.status));
		if (got.front_value !== want.front_value)
			report_mismatch("front_value", got.front_value, want.front_value);
		if (got.back_value !== want.back_value)
			report_mismatch("back_value", got.back_value, want.back_value);
		if (got.entry_count !== want.entry_count)
			report_mismatch("entry_count", 32'(got.entry_count), 32'(want.entry_count));
		if (got.is_empty !== want.is_empty)
			report_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
		reply_idx++;
	endtask

	// predict first so a same-edge reply still finds its entry in order
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				pending_replies = {pending_replies, apply_request(req)};
			if (rsp_valid && !rsp_stall)
				compare_reply(rsp);
			outstanding <= pending_replies.size();
		end
	end

endmodule

// ===== sim/double_ended_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Drives request beats into the deque: a directed run over the empty, single
// entry, full and wrapped cases, then random push/pop bursts under three
// idling profiles and one long reply hold-off. The checker beside the block
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
	import deq_pkg::*;

	localparam logic [2:0] REQ_UNUSED = 3'd7;
	localparam int RANDOM_ITEMS   = 800;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int HOLD_CYCLES    = 80;
	localparam int HOLD_AT_ITEM   = 650;

	typedef enum {MIX_BALANCED, MIX_FILL, MIX_DRAIN} mix_t;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	deq_req_t req       = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	deq_rsp_t rsp;

	int   mismatches;
	int   outstanding;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   items_sent    = 0;
	int   quiet_cycles  = 0;
	logic rsp_hold      = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	double_ended_queue i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	double_ended_queue_chk i_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always @(negedge clk) begin
		rsp_stall <= rsp_hold || ($urandom_range(99) < recv_idle_pct);
	end

	// long hold-off on the reply side while requests keep coming
	initial begin
		wait (items_sent >= HOLD_AT_ITEM);
		@(posedge clk);
		rsp_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rsp_hold <= 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(15))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'sd0;
			3: return -32'sd1;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [2:0] pick_kind(input mix_t mix);
		int roll;
		int push_pct;
		int pop_pct;
		roll = $urandom_range(99);
		case (mix)
			MIX_FILL: begin
				push_pct = 70;
				pop_pct  = 15;
			end
			MIX_DRAIN: begin
				push_pct = 15;
				pop_pct  = 70;
			end
			default: begin
				push_pct = 42;
				pop_pct  = 42;
			end
		endcase
		if (roll < push_pct)
			return $urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
		roll -= push_pct;
		if (roll < pop_pct)
			return $urandom_range(1) ? REQ_POP_FRONT : REQ_POP_BACK;
		roll -= pop_pct;
		if (roll < 8)
			return REQ_REVERSE;
		if (roll < 11)
			return REQ_PEEK;
		if (roll < 13)
			return REQ_UNUSED;
		return (mix == MIX_BALANCED) ? REQ_CLEAR : REQ_REVERSE;
	endfunction

	// hold the beat until it is taken
	task automatic send_request(input logic [2:0] kind, input logic signed [31:0] value);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= '{req_type: kind, push_value: value};
		do @(posedge clk); while (!(req_valid && !req_stall));
		items_sent++;
	endtask

	initial begin
		mix_t mix;
		int   seg_left;
		int   per_phase;
		seg_left  = 0;
		per_phase = RANDOM_ITEMS / 3;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// empty queue: peek, both pops underflow, reverse with nothing stored
		send_request(REQ_PEEK, pick_word());
		send_request(REQ_POP_FRONT, pick_word());
		send_request(REQ_POP_BACK, pick_word());
		send_request(REQ_REVERSE, pick_word());
		send_request(REQ_PUSH_FRONT, 32'sh7fffffff);
		send_request(REQ_REVERSE, pick_word());
		send_request(REQ_PUSH_BACK, 32'sh80000000);
		send_request(REQ_UNUSED, pick_word());
		send_request(REQ_POP_FRONT, pick_word());
		send_request(REQ_POP_BACK, pick_word());
		// fill from both ends so the head wraps, then push into a full ring
		for (int k = 0; k < DEQ_DEPTH; k++)
			send_request(k[0] ? REQ_PUSH_BACK : REQ_PUSH_FRONT,
				(k == 0) ? 32'sd0 : (k == 1) ? -32'sd1 : $urandom());
		send_request(REQ_PUSH_FRONT, pick_word());
		send_request(REQ_PUSH_BACK, pick_word());
		send_request(REQ_REVERSE, pick_word());
		send_request(REQ_POP_BACK, pick_word());
		send_request(REQ_CLEAR, pick_word());

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 17;
					recv_idle_pct = 48;
				end
				1: begin
					send_idle_pct = 48;
					recv_idle_pct = 17;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < per_phase; n++) begin
				if (seg_left == 0) begin
					mix      = mix_t'($urandom_range(2));
					seg_left = $urandom_range(8, 40);
				end
				send_request(pick_kind(mix), pick_word());
				seg_left--;
			end
		end

		@(negedge clk);
		req_valid <= 1'b0;
		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/deq_pkg.sv
rtl/core/deq_ram.sv
rtl/core/deq_ctrl.sv
rtl/core/deq_dp.sv
rtl/core/double_ended_queue.sv
rtl/core/deq_chk.sv
sim/double_ended_queue_chk.sv
sim/double_ended_queue_tb.sv
